@@ rtl/trm_pkg.sv @@
// ----------------------------------------------------------------------------
// trm_pkg
// Types, opcodes and fixed sizes shared by the register machine files.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int DATA_W    = 32;
  localparam int IMM_W     = 16;
  localparam int MEM_WORDS = 1024;
  localparam int MEM_AW    = 10;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_LVL_W = 3;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [7:0]        opcode_t;

  localparam opcode_t OP_PRINT = 8'd0;
  localparam opcode_t OP_IMM   = 8'd1;
  localparam opcode_t OP_ADD   = 8'd2;
  localparam opcode_t OP_STORE = 8'd3;
  localparam opcode_t OP_LOAD  = 8'd4;
  localparam opcode_t OP_MUL   = 8'd5;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_PRINT,
    KIND_IMM,
    KIND_ADD,
    KIND_STORE,
    KIND_LOAD,
    KIND_MUL
  } kind_t;

  function automatic kind_t decode(opcode_t op);
    kind_t k;
    unique case (op)
      OP_PRINT: k = KIND_PRINT;
      OP_IMM:   k = KIND_IMM;
      OP_ADD:   k = KIND_ADD;
      OP_STORE: k = KIND_STORE;
      OP_LOAD:  k = KIND_LOAD;
      OP_MUL:   k = KIND_MUL;
      default:  k = KIND_NOP;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/trm_ram.sv @@
// ----------------------------------------------------------------------------
// trm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module trm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/trm_outq.sv @@
// ----------------------------------------------------------------------------
// trm_outq
// Small result queue that decouples the pipeline from the output stall.
// ----------------------------------------------------------------------------
module trm_outq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  trm_pkg::word_t           push_data,
  output logic                     valid,
  input  logic                     stall,
  output trm_pkg::word_t           data,
  output logic [trm_pkg::OUT_LVL_W-1:0] level
);
  import trm_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);

  word_t            slots [OUT_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             pop;

  assign valid = (level != '0);
  assign data  = slots[rd_ptr];
  assign pop   = valid && !stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + OUT_LVL_W'(push) - OUT_LVL_W'(pop);
    end
  end

endmodule

@@ rtl/toy_register_machine_step.sv @@
// ----------------------------------------------------------------------------
// toy_register_machine_step
// Register machine: one instruction per item on a RAM register file and a
// RAM data memory, with operand forwarding and a small result queue.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// in       in_valid / in_stall   operation, dest_reg, arg_b, arg_c
// out      out_valid / out_stall printed_value
//
// One item per cycle while in_stall is low; prints go via s1, s2 and the result queue.
// Register reads go through two RAM banks with forwarding from the two writes
// still in flight; the data memory is read and written by the execute stage.
// After reset all 1024 data memory words are cleared while in_stall is high.
// in_stall also rises when queued plus in-flight prints fill the four-entry
// result queue.
// ----------------------------------------------------------------------------
module toy_register_machine_step #(
  parameter int REG_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        operation,
  input  logic [4:0]                        dest_reg,
  input  logic [7:0]                        arg_b,
  input  logic [7:0]                        arg_c,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [trm_pkg::DATA_W-1:0] printed_value
);
  import trm_pkg::*;

  localparam int RAW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int IDX_N = 256;

  logic [RAW-1:0] reg_mod [IDX_N];

  genvar gi;
  generate
    for (gi = 0; gi < IDX_N; gi++) begin : g_mod
      assign reg_mod[gi] = RAW'(gi % REG_COUNT);
    end
  endgenerate

  logic               in_accept;
  kind_t              in_kind;
  logic [RAW-1:0]     rd_a_addr;
  logic [RAW-1:0]     rd_b_addr;
  word_t              rf_a_q;
  word_t              rf_b_q;

  logic               s1_valid;
  kind_t              s1_kind;
  logic [RAW-1:0]     s1_ia;
  logic [RAW-1:0]     s1_ib;
  logic [RAW-1:0]     s1_d;
  logic [IMM_W-1:0]   s1_imm;

  logic               s2_wen;
  logic               s2_print;
  logic               s2_load;
  logic [RAW-1:0]     s2_d;
  word_t              s2_alu;
  word_t              s2_wdata;

  logic               last_wen;
  logic [RAW-1:0]     last_d;
  word_t              last_wdata;

  logic [REG_COUNT-1:0] reg_valid;
  word_t              reg0;

  word_t              opa;
  word_t              opb;
  word_t              alu;
  logic               s1_wr;

  logic [MEM_AW:0]    clr_cnt;
  logic               clearing;
  logic               dm_we;
  logic [MEM_AW-1:0]  dm_addr;
  word_t              dm_wdata;
  word_t              dm_q;

  logic [OUT_LVL_W-1:0] q_level;
  word_t              q_data;
  logic [3:0]         committed;

  assign clearing  = !clr_cnt[MEM_AW];
  assign committed = 4'(q_level) + 4'(s1_valid && s1_kind == KIND_PRINT) + 4'(s2_print);
  assign in_stall  = clearing || (committed >= 4'(OUT_DEPTH));
  assign in_accept = in_valid && !in_stall;

  assign in_kind   = decode(operation);
  assign rd_a_addr = reg_mod[arg_b];
  assign rd_b_addr = (in_kind == KIND_STORE) ? reg_mod[8'(dest_reg)] : reg_mod[arg_c];

  trm_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT), .AW(RAW)) u_rf_a (
    .clk   (clk),
    .we    (s2_wen),
    .waddr (s2_d),
    .wdata (s2_wdata),
    .raddr (rd_a_addr),
    .rdata (rf_a_q)
  );

  trm_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT), .AW(RAW)) u_rf_b (
    .clk   (clk),
    .we    (s2_wen),
    .waddr (s2_d),
    .wdata (s2_wdata),
    .raddr (rd_b_addr),
    .rdata (rf_b_q)
  );

  function automatic word_t fwd(logic [RAW-1:0] idx, word_t ram_q);
    word_t v;
    if (s2_wen && s2_d == idx) begin
      v = s2_wdata;
    end else if (last_wen && last_d == idx) begin
      v = last_wdata;
    end else if (reg_valid[idx]) begin
      v = ram_q;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  always_comb begin
    opa = fwd(s1_ia, rf_a_q);
    opb = fwd(s1_ib, rf_b_q);
  end

  always_comb begin
    alu   = '0;
    s1_wr = 1'b0;
    unique case (s1_kind)
      KIND_IMM: begin
        alu   = DATA_W'(s1_imm);
        s1_wr = 1'b1;
      end
      KIND_ADD: begin
        alu   = opa + opb;
        s1_wr = 1'b1;
      end
      KIND_MUL: begin
        alu   = opa * opb;
        s1_wr = 1'b1;
      end
      KIND_LOAD: begin
        s1_wr = 1'b1;
      end
      KIND_NOP, KIND_PRINT, KIND_STORE: begin
        s1_wr = 1'b0;
      end
      default: begin
        s1_wr = 1'b0;
      end
    endcase
  end

  assign dm_we    = clearing || (s1_valid && s1_kind == KIND_STORE);
  assign dm_addr  = clearing ? clr_cnt[MEM_AW-1:0] : opa[MEM_AW-1:0];
  assign dm_wdata = clearing ? '0 : opb;

  trm_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS), .AW(MEM_AW)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_addr),
    .wdata (dm_wdata),
    .raddr (dm_addr),
    .rdata (dm_q)
  );

  assign s2_wdata = s2_load ? dm_q : s2_alu;

  always_ff @(posedge clk) begin
    s1_kind <= in_kind;
    s1_ia   <= rd_a_addr;
    s1_ib   <= rd_b_addr;
    s1_d    <= reg_mod[8'(dest_reg)];
    s1_imm  <= {arg_b, arg_c};
    s2_d    <= s1_d;
    s2_alu  <= alu;
    s2_load <= (s1_kind == KIND_LOAD);
    last_d     <= s2_d;
    last_wdata <= s2_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      s1_valid  <= 1'b0;
      s2_wen    <= 1'b0;
      s2_print  <= 1'b0;
      last_wen  <= 1'b0;
      reg_valid <= '0;
      reg0      <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      s1_valid <= in_accept;
      s2_wen   <= s1_valid && s1_wr;
      s2_print <= s1_valid && s1_kind == KIND_PRINT;
      last_wen <= s2_wen;
      if (s2_wen) begin
        reg_valid[s2_d] <= 1'b1;
        if (s2_d == '0) begin
          reg0 <= s2_wdata;
        end
      end
    end
  end

  trm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_print),
    .push_data (reg0),
    .valid     (out_valid),
    .stall     (out_stall),
    .data      (q_data),
    .level     (q_level)
  );

  assign printed_value = q_data;

endmodule

@@ rtl/trm_checker.sv @@
// ----------------------------------------------------------------------------
// trm_checker
// Port-level checks for the register machine, bound to the top level.
// ----------------------------------------------------------------------------
module trm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [7:0]                        operation,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [trm_pkg::DATA_W-1:0] printed_value
);
  import trm_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled during memory clear");

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(printed_value))
    else $error("stalled result changed");

  a_print_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc && operation == OP_PRINT, 3))
    else $error("result without a matching print item");

endmodule

bind toy_register_machine_step trm_checker u_trm_checker (.*);
